/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked on i_clk, inactive while i_rst_n is low
`define SIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion checked on i_clk, also during reset
`define SIT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/sit_pkg.sv */
`default_nettype none

package sit_pkg;

    // Field widths
    localparam int CYC_W  = 16;
    localparam int CPL_W  = 12;
    localparam int BYTE_W = 8;
    localparam int VEC_W  = 11;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = CYC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Line constants
    localparam logic [BYTE_W-1:0] FRAME_LINE = 8'd144;
    localparam logic [BYTE_W-1:0] LAST_LINE  = 8'd158;
    localparam logic [CPL_W-1:0]  CPL_RESET  = 12'd256;

    // Interrupt enable bit positions
    localparam int EN_MATCH   = 4;
    localparam int EN_VBL_END = 5;
    localparam int EN_VBL     = 6;
    localparam int EN_TIMER   = 7;

    // Vector offsets
    localparam logic [BYTE_W:0] VEC_MATCH   = 9'd4;
    localparam logic [BYTE_W:0] VEC_VBL_END = 9'd5;
    localparam logic [BYTE_W:0] VEC_VBL     = 9'd6;
    localparam logic [BYTE_W:0] VEC_TIMER   = 9'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
    } t_status;

    // (base + k) * 4, truncated to the vector width
    function automatic logic [VEC_W-1:0] vec_of(input logic [BYTE_W-1:0] base,
                                                input logic [BYTE_W:0] k);
        logic [BYTE_W:0] sum;
        sum = {1'b0, base} + k;
        return {sum, 2'b00};
    endfunction

endpackage

`default_nettype wire

/* rtl/sit_if.sv */
`default_nettype none

// Line step input channel
interface sit_in_if import sit_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CYC_W-1:0]  cpu_cycles;
    logic [BYTE_W-1:0] int_enable;
    logic [BYTE_W-1:0] vector_base;
    logic [BYTE_W-1:0] timer_reload;
    logic [BYTE_W-1:0] line_compare;

    modport source (output valid, cpu_cycles, int_enable, vector_base, timer_reload,
                    line_compare, input ready);
    modport sink   (input valid, cpu_cycles, int_enable, vector_base, timer_reload,
                    line_compare, output ready);
endinterface

// Result output channel
interface sit_out_if import sit_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] current_line;
    logic              frame_done;
    logic [CYC_W-1:0]  lines_advanced;
    logic              vblank_end_fire;
    logic              vblank_fire;
    logic              timer_fire;
    logic              line_match_fire;
    logic [VEC_W-1:0]  vblank_end_vector;
    logic [VEC_W-1:0]  vblank_vector;
    logic [VEC_W-1:0]  timer_vector;
    logic [VEC_W-1:0]  line_match_vector;

    modport source (output valid, current_line, frame_done, lines_advanced,
                    vblank_end_fire, vblank_fire, timer_fire, line_match_fire,
                    vblank_end_vector, vblank_vector, timer_vector, line_match_vector,
                    input ready);
    modport sink   (input valid, current_line, frame_done, lines_advanced,
                    vblank_end_fire, vblank_fire, timer_fire, line_match_fire,
                    vblank_end_vector, vblank_vector, timer_vector, line_match_vector,
                    output ready);
endinterface

// Configuration write channel (cycles_per_line)
interface sit_cfg_if import sit_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CPL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/sit_ctrl.sv */
`default_nettype none

`include "assert_macros.svh"

module sit_ctrl import sit_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_cmd         o_cmd,
    input  wire t_status i_status
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Output register can take a new result
    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_FIN: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SIT_ASSERT(a_accept_starts_div, (i_in_valid && o_in_ready) |=> (r_state == S_DIV),
        "accepted transaction did not start the divider")
    `SIT_ASSERT(a_last_step_to_fin, (r_state == S_DIV && i_status.div_last) |=> (r_state == S_FIN),
        "divider finished without moving to finish state")
    `SIT_ASSERT(a_commit_sets_valid, o_cmd.commit |=> r_out_valid,
        "committed result not presented")

endmodule

`default_nettype wire

/* rtl/sit_datapath.sv */
`default_nettype none

`include "assert_macros.svh"

module sit_datapath import sit_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [CPL_W-1:0]  i_cfg_data,
    // line step fields
    input  wire logic [CYC_W-1:0]  i_cpu_cycles,
    input  wire logic [BYTE_W-1:0] i_int_enable,
    input  wire logic [BYTE_W-1:0] i_vector_base,
    input  wire logic [BYTE_W-1:0] i_timer_reload,
    input  wire logic [BYTE_W-1:0] i_line_compare,
    // result fields
    output logic [BYTE_W-1:0] o_current_line,
    output logic              o_frame_done,
    output logic [CYC_W-1:0]  o_lines_advanced,
    output logic              o_vblank_end_fire,
    output logic              o_vblank_fire,
    output logic              o_timer_fire,
    output logic              o_line_match_fire,
    output logic [VEC_W-1:0]  o_vblank_end_vector,
    output logic [VEC_W-1:0]  o_vblank_vector,
    output logic [VEC_W-1:0]  o_timer_vector,
    output logic [VEC_W-1:0]  o_line_match_vector
);

    // Configuration and state
    logic [CPL_W-1:0]  r_cpl;
    logic [BYTE_W-1:0] r_lc, n_lc;
    logic [BYTE_W-1:0] r_tc, n_tc;

    // Latched transaction
    logic [CPL_W-1:0]  r_cpl_eff;
    logic [CYC_W-1:0]  r_cycles;
    logic [BYTE_W-1:0] r_en, r_base, r_reload, r_cmp;

    // Divider
    logic [CNT_W-1:0]  r_cnt;
    logic [CPL_W-1:0]  r_rem, n_rem;
    logic [CYC_W-1:0]  r_quo, n_quo;
    logic [CPL_W:0]    rem_sh;
    logic              ge;

    // Finish logic
    logic [CYC_W-1:0]  lines;
    logic [BYTE_W-1:0] d8;
    logic [BYTE_W:0]   frame_gap;
    logic [BYTE_W-1:0] line_sum;
    logic [BYTE_W-1:0] line_new;
    logic              frame, vbl_end, tmr, match;
    logic [BYTE_W-1:0] t_ld;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpl <= CPL_RESET;
        end else if (i_cfg_we) begin
            r_cpl <= i_cfg_data;
        end
    end

    // Restoring divide step
    always_comb begin
        rem_sh = {r_rem, r_quo[CYC_W-1]};
        ge     = rem_sh >= {1'b0, r_cpl_eff};
        n_rem  = ge ? CPL_W'(rem_sh - {1'b0, r_cpl_eff}) : rem_sh[CPL_W-1:0];
        n_quo  = {r_quo[CYC_W-2:0], ge};
    end

    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    // Transaction latch and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cpl_eff <= (r_cpl == '0) ? CPL_W'(1) : r_cpl;
            r_cycles  <= i_cpu_cycles;
            r_en      <= i_int_enable;
            r_base    <= i_vector_base;
            r_reload  <= i_timer_reload;
            r_cmp     <= i_line_compare;
            r_rem     <= '0;
            r_quo     <= i_cpu_cycles;
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Line advance, frame, vblank, timer and match
    always_comb begin
        lines     = (r_cycles >= {3'b000, r_cpl_eff, 1'b0}) ? r_quo : CYC_W'(1);
        d8        = (FRAME_LINE - BYTE_W'(1)) - r_lc;
        frame_gap = {1'b0, d8} + 9'd1;
        frame     = lines >= {{(CYC_W-BYTE_W-1){1'b0}}, frame_gap};
        line_sum  = r_lc + lines[BYTE_W-1:0];
        vbl_end   = 1'b0;
        line_new  = line_sum;
        if (line_sum > LAST_LINE) begin
            line_new = '0;
            vbl_end  = r_en[EN_VBL_END];
        end
        n_lc = line_new;
        // line timer
        n_tc = r_tc;
        tmr  = 1'b0;
        t_ld = (r_tc == '0) ? r_reload : r_tc;
        if (r_reload != '0 && r_en[EN_TIMER]) begin
            n_tc = t_ld - BYTE_W'(1);
            tmr  = (n_tc == '0);
        end
        match = (line_new == r_cmp) && r_en[EN_MATCH];
    end

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc <= '0;
            r_tc <= '0;
        end else if (i_cmd.commit) begin
            r_lc <= n_lc;
            r_tc <= n_tc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_current_line      <= line_new;
            o_frame_done        <= frame;
            o_lines_advanced    <= lines;
            o_vblank_end_fire   <= vbl_end;
            o_vblank_fire       <= frame && r_en[EN_VBL];
            o_timer_fire        <= tmr;
            o_line_match_fire   <= match;
            o_vblank_end_vector <= vec_of(r_base, VEC_VBL_END);
            o_vblank_vector     <= vec_of(r_base, VEC_VBL);
            o_timer_vector      <= vec_of(r_base, VEC_TIMER);
            o_line_match_vector <= vec_of(r_base, VEC_MATCH);
        end
    end

    `SIT_ASSERT(a_load_clears_cnt, i_cmd.load |=> (r_cnt == '0),
        "step counter not cleared on load")
    `SIT_ASSERT(a_cpl_nonzero, $past(i_cmd.load) |-> (r_cpl_eff != '0),
        "divisor latched as zero")

endmodule

`default_nettype wire

/* rtl/scanline_interrupt_timer_top.sv */
// A line step accepted in S_IDLE is latched, then divided in S_DIV by the 16-step shift-subtract
// divider, then committed to the result register in S_FIN once the output register is free.
// A new line step is accepted only after that commit; the next step is taken while a result waits.
// Reset (synchronous, active low): line counter and line timer to 0,
// cycles_per_line to 256, no result pending.
`default_nettype none

module scanline_interrupt_timer_top import sit_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sit_in_if.sink    i_in_ch,
    sit_out_if.source o_out_ch,
    sit_cfg_if.sink  i_cfg_ch
);

    t_cmd    cmd;
    t_status status;

    // Configuration is always writable
    assign i_cfg_ch.ready = 1'b1;

    sit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    sit_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_ch.valid),
        .i_cfg_data          (i_cfg_ch.data),
        .i_cpu_cycles        (i_in_ch.cpu_cycles),
        .i_int_enable        (i_in_ch.int_enable),
        .i_vector_base       (i_in_ch.vector_base),
        .i_timer_reload      (i_in_ch.timer_reload),
        .i_line_compare      (i_in_ch.line_compare),
        .o_current_line      (o_out_ch.current_line),
        .o_frame_done        (o_out_ch.frame_done),
        .o_lines_advanced    (o_out_ch.lines_advanced),
        .o_vblank_end_fire   (o_out_ch.vblank_end_fire),
        .o_vblank_fire       (o_out_ch.vblank_fire),
        .o_timer_fire        (o_out_ch.timer_fire),
        .o_line_match_fire   (o_out_ch.line_match_fire),
        .o_vblank_end_vector (o_out_ch.vblank_end_vector),
        .o_vblank_vector     (o_out_ch.vblank_vector),
        .o_timer_vector      (o_out_ch.timer_vector),
        .o_line_match_vector (o_out_ch.line_match_vector)
    );

endmodule

`default_nettype wire
